@@ rtl/div64_pkg.sv @@
package div64_pkg;

  localparam int NUM_W     = 64;
  localparam int DEN_W     = 32;
  // One quotient bit is resolved in each cell of the chain.
  localparam int DIV_STEPS = NUM_W;

  typedef struct packed {
    logic             op;
    logic [NUM_W-1:0] dividend;
    logic [DEN_W-1:0] divisor;
  } in_t;

  typedef struct packed {
    logic [NUM_W-1:0] quotient;
    logic [NUM_W-1:0] remainder;
    logic             div_by_zero;
  } out_t;

  // Working state that travels from cell to cell.
  typedef struct packed {
    logic             vld;
    logic             dbz;
    logic             q_neg;
    logic             r_neg;
    logic [DEN_W-1:0] den;
    logic [DEN_W-1:0] rem;
    logic [NUM_W-1:0] dq;
  } cell_t;

endpackage

@@ rtl/div64_cell.sv @@
module div64_cell
  import div64_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  cell_t cell_in,
  output cell_t cell_out
);

  // The upper bits of dq hold the dividend bits still to be consumed; the lower bits
  // collect quotient bits as they are resolved.
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W+1:0] diff;
  logic             ge;
  logic [DEN_W-1:0] rem_nxt;
  logic [NUM_W-1:0] dq_nxt;
  logic             vld_r;
  cell_t            data_r;

  always_comb begin
    rem_sh = {cell_in.rem, cell_in.dq[NUM_W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, cell_in.den};
    ge     = ~diff[DEN_W+1];
    if (cell_in.dbz) begin
      // A zero divisor leaves the dividend in place for the remainder field.
      rem_nxt = cell_in.rem;
      dq_nxt  = cell_in.dq;
    end else begin
      rem_nxt = ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      dq_nxt  = {cell_in.dq[NUM_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= cell_in.vld;
    end
    data_r.vld   <= 1'b0;
    data_r.dbz   <= cell_in.dbz;
    data_r.q_neg <= cell_in.q_neg;
    data_r.r_neg <= cell_in.r_neg;
    data_r.den   <= cell_in.den;
    data_r.rem   <= rem_nxt;
    data_r.dq    <= dq_nxt;
  end

  always_comb begin
    cell_out     = data_r;
    cell_out.vld = vld_r;
  end

endmodule

@@ rtl/divide_64_by_32_quotient_remainder.sv @@
// Throughput: one transaction per cycle while busy is low, set by the 64-cell restoring
// divider chain, one quotient bit per cell, with one operand stage in front and one sign
// stage behind.
// Reset (synchronous, rst_n low) clears all valid bits and holds busy high until one cycle
// after release. The receiver cannot stall: each result is shown for exactly one cycle.
module divide_64_by_32_quotient_remainder
  import div64_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_valid,
  output out_t out_data
);

  // Busy is only raised around reset; otherwise the chain takes a new transaction every cycle.
  logic busy_r;
  logic accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start & ~busy_r;

  // Operand stage. In signed mode both operands are turned into magnitudes and the signs
  // of the quotient and remainder are remembered for the final stage. The divisor's
  // magnitude always fits 32 bits, the most negative divisor included.
  logic             num_neg;
  logic             den_neg;
  logic [NUM_W-1:0] num_mag;
  logic [DEN_W-1:0] den_mag;
  logic             dbz;
  cell_t            pre_nxt;
  logic             pre_vld_r;
  cell_t            pre_data_r;
  cell_t            chain [0:DIV_STEPS];

  always_comb begin
    num_neg = in_data.op & in_data.dividend[NUM_W-1];
    den_neg = in_data.op & in_data.divisor[DEN_W-1];
    num_mag = num_neg ? (~in_data.dividend + {{(NUM_W-1){1'b0}}, 1'b1}) : in_data.dividend;
    den_mag = den_neg ? (~in_data.divisor + {{(DEN_W-1){1'b0}}, 1'b1}) : in_data.divisor;
    dbz     = (in_data.divisor == '0);

    pre_nxt.vld   = 1'b0;
    pre_nxt.dbz   = dbz;
    pre_nxt.q_neg = ~dbz & (num_neg ^ den_neg);
    pre_nxt.r_neg = ~dbz & num_neg;
    pre_nxt.den   = den_mag;
    pre_nxt.rem   = '0;
    // With a zero divisor the raw dividend is carried through untouched as the remainder.
    pre_nxt.dq    = dbz ? in_data.dividend : num_mag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_vld_r <= 1'b0;
    end else begin
      pre_vld_r <= accept;
    end
    pre_data_r <= pre_nxt;
  end

  always_comb begin
    chain[0]     = pre_data_r;
    chain[0].vld = pre_vld_r;
  end

  // The divider chain: each cell shifts one dividend bit into the remainder, trial-subtracts the divisor
  // and shifts one quotient bit into dq (not under a zero divisor), handing its state to the next cell every cycle.
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_cell
    div64_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_in  (chain[k]),
      .cell_out (chain[k+1])
    );
  end

  // Sign stage. Unless the divisor is zero, the quotient is negated when the operand signs differ and the
  // remainder takes the dividend's sign. The most negative dividend over minus one wraps naturally.
  cell_t            last;
  logic [NUM_W-1:0] rem_ext;
  out_t             out_nxt;
  logic             out_valid_r;
  out_t             out_data_r;

  always_comb begin
    last    = chain[DIV_STEPS];
    rem_ext = {{(NUM_W-DEN_W){1'b0}}, last.rem};
    if (last.dbz) begin
      out_nxt.quotient  = '1;
      out_nxt.remainder = last.dq;
    end else begin
      out_nxt.quotient  = last.q_neg ? (~last.dq + {{(NUM_W-1){1'b0}}, 1'b1}) : last.dq;
      out_nxt.remainder = last.r_neg ? (~rem_ext + {{(NUM_W-1){1'b0}}, 1'b1}) : rem_ext;
    end
    out_nxt.div_by_zero = last.dbz;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= last.vld;
    end
    out_data_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A zero divisor must always give an all-ones quotient.
  a_dbz_quotient: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.div_by_zero |-> (&out_data.quotient))
    else $error("zero divisor result without all-ones quotient");

  // A remainder is below 2^32 in magnitude, so its upper half holds only zeros or only ones.
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.div_by_zero |->
      ((out_data.remainder[NUM_W-1:DEN_W] == '0) || (&out_data.remainder[NUM_W-1:DEN_W])))
    else $error("remainder exceeds divisor range");

  // The cells must not disturb the partial remainder while a zero divisor passes through.
  a_dbz_rem_held: assert property (@(posedge clk) disable iff (!rst_n)
    last.vld && last.dbz |-> (last.rem == '0))
    else $error("partial remainder changed under zero divisor");

endmodule
